// File: src/assert_macros.svh
// assert_macros.svh: concurrent assertion macros for the projection checker
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define CHK_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/rpj_pkg.sv
// rpj_pkg: widths, codes, types and rounding helpers of the ray projection block
// no dependencies; imported by every module of the block
`default_nettype none

package rpj_pkg;

    // number format
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int RAD_W     = DATA_W - 1;

    // divider geometry
    localparam int TERM_W  = DATA_W + 2;
    localparam int NUM_W   = TERM_W + FRAC_BITS;
    localparam int DEN_W   = DATA_W + 2;
    localparam int QUO_W   = DATA_W + 1;
    localparam int REM_W   = NUM_W + 1;
    localparam int CMP_W   = DEN_W + QUO_W + 1;
    localparam int DIV_LAT = QUO_W + 2;

    // square root geometry
    localparam int ROOT_W   = DATA_W;
    localparam int SQRT_LAT = ROOT_W + 1;

    // accept edge to result strobe
    localparam int PIPE_LAT = 2 * DIV_LAT + SQRT_LAT + 10;

    // register indexes
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_FRONT_CAM_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRONT_CAM_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_FRONT_CAM_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_REAR_CAM_X  = 3'd3;
    localparam logic [IDX_W-1:0] REG_REAR_CAM_Y  = 3'd4;
    localparam logic [IDX_W-1:0] REG_REAR_CAM_Z  = 3'd5;
    localparam logic [IDX_W-1:0] REG_CYL_RADIUS  = 3'd6;

    // status codes
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_ROOT  = 2'd1;
    localparam logic [ST_W-1:0] ST_PARALLEL = 2'd2;

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t W_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t W_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [RAD_W-1:0]         RESET_RADIUS = RAD_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0]  FOUR_ONE     = SUM_W'(4) << FRAC_BITS;
    localparam logic [PROD_W-1:0]        HALF_P       = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0]  SAT_HI       = SUM_W'(W_MAX);
    localparam logic signed [SUM_W-1:0]  SAT_LO       = SUM_W'(W_MIN);
    localparam logic [QUO_W-1:0]         Q_LIM        = QUO_W'(1) << (DATA_W - 1);

    // per-item control and payload that travels down the pipeline
    typedef struct packed {
        logic  v;
        logic  sel;
        logic  zdz;
        logic  neg;
        word_t py;
        word_t rx;
        word_t ry;
        word_t part;
        word_t a;
        word_t h;
    } item_t;

    // one stage of the restoring divider
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] q;
        logic [DEN_W-1:0] ud;
        logic             neg;
        logic             ovf;
    } dstage_t;

    // one stage of the square root
    typedef struct packed {
        logic [PROD_W-1:0] v;
        logic [PROD_W-1:0] res;
    } sstage_t;

    // product scaled down by 2^FRAC_BITS, rounded half away from zero
    function automatic logic signed [SUM_W-1:0] rs_rnd(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0]       m;
        logic [PROD_W-1:0]       r;
        logic signed [SUM_W-1:0] s;
        m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        r = (m + HALF_P) >> FRAC_BITS;
        s = $signed(SUM_W'(r));
        return p[PROD_W-1] ? -s : s;
    endfunction

    // clamp to the signed 32-bit range
    function automatic word_t sat32(input logic signed [SUM_W-1:0] x);
        word_t r;
        if (x > SAT_HI) begin
            r = W_MAX;
        end else if (x < SAT_LO) begin
            r = W_MIN;
        end else begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/rpj_div.sv
// rpj_div: pipelined restoring divider, rounded half away from zero, saturated result
// depends on rpj_pkg; one quotient bit per stage
`default_nettype none

module rpj_div import rpj_pkg::*;
(
    input  logic                    clk,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output word_t                   quo
);

    dstage_t          st_reg [QUO_W+1];
    dstage_t          st_next [QUO_W];
    dstage_t          prep_next;
    word_t            quo_reg;
    word_t            quo_next;
    logic [NUM_W-1:0] un;
    logic [DEN_W-1:0] ud;
    logic [REM_W-1:0] nr;

    // magnitudes, rounding bias and overflow precheck
    always_comb
    begin
        un = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        ud = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        nr = REM_W'(un) + REM_W'(ud >> 1);
        prep_next.rem = nr;
        prep_next.q   = '0;
        prep_next.ud  = ud;
        prep_next.neg = num[NUM_W-1] ^ den[DEN_W-1];
        prep_next.ovf = CMP_W'(nr) >= (CMP_W'(ud) << QUO_W);
    end

    // one trial subtraction per stage
    for (genvar i = 0; i < QUO_W; i++) begin : g_step
        logic [CMP_W-1:0] trial;
        assign trial = CMP_W'(st_reg[i].ud) << (QUO_W - 1 - i);
        always_comb
        begin
            st_next[i] = st_reg[i];
            if (CMP_W'(st_reg[i].rem) >= trial) begin
                st_next[i].rem              = REM_W'(CMP_W'(st_reg[i].rem) - trial);
                st_next[i].q[QUO_W - 1 - i] = 1'b1;
            end
        end
    end

    // sign and saturation
    always_comb
    begin
        if (st_reg[QUO_W].ovf) begin
            quo_next = st_reg[QUO_W].neg ? W_MIN : W_MAX;
        end else if (st_reg[QUO_W].neg) begin
            quo_next = (st_reg[QUO_W].q > Q_LIM) ? W_MIN : DATA_W'(-st_reg[QUO_W].q);
        end else begin
            quo_next = (st_reg[QUO_W].q >= Q_LIM) ? W_MAX : DATA_W'(st_reg[QUO_W].q);
        end
    end

    // data-only pipeline
    always_ff @(posedge clk)
    begin
        st_reg[0] <= prep_next;
        for (int k = 0; k < QUO_W; k++) begin
            st_reg[k+1] <= st_next[k];
        end
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// File: src/rpj_sqrt.sv
// rpj_sqrt: pipelined integer square root, floor of the root of a 64-bit value
// depends on rpj_pkg; two radicand bits per stage
`default_nettype none

module rpj_sqrt import rpj_pkg::*;
(
    input  logic              clk,
    input  logic [PROD_W-1:0] rad,
    output logic [ROOT_W-1:0] root
);

    sstage_t st_reg [ROOT_W+1];
    sstage_t st_next [ROOT_W];

    // one digit-by-digit step per stage
    for (genvar i = 0; i < ROOT_W; i++) begin : g_step
        logic [PROD_W-1:0] bitv;
        logic [PROD_W-1:0] trial;
        assign bitv  = PROD_W'(1) << (PROD_W - 2 - 2 * i);
        assign trial = st_reg[i].res + bitv;
        always_comb
        begin
            if (st_reg[i].v >= trial) begin
                st_next[i].v   = st_reg[i].v - trial;
                st_next[i].res = (st_reg[i].res >> 1) + bitv;
            end else begin
                st_next[i].v   = st_reg[i].v;
                st_next[i].res = st_reg[i].res >> 1;
            end
        end
    end

    // data-only pipeline
    always_ff @(posedge clk)
    begin
        st_reg[0].v   <= rad;
        st_reg[0].res <= '0;
        for (int k = 0; k < ROOT_W; k++) begin
            st_reg[k+1] <= st_next[k];
        end
    end

    assign root = st_reg[ROOT_W].res[ROOT_W-1:0];

endmodule

`default_nettype wire

// File: src/ray_elliptic_cylinder_projection.sv
// Structure: each item taken with start passes two pipelined dividers, a root pipeline
// and ten math stages before its result strobes on done.
// Throughput: one item per cycle; busy stays low and results cannot be held off.
// Reset: rst_n clears all valid bits and loads the register reset values.
// depends on rpj_pkg, rpj_div, rpj_sqrt
`default_nettype none

module ray_elliptic_cylinder_projection import rpj_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  word_t            pt_x,
    input  word_t            pt_y,
    input  word_t            pt_z,
    input  logic             side,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [DATA_W-1:0] wr_data,
    output logic             done,
    output word_t            hit_x,
    output word_t            hit_y,
    output word_t            hit_z,
    output logic [ST_W-1:0]  status
);

    // configuration registers
    word_t            front_cam_x_reg, front_cam_y_reg, front_cam_z_reg;
    word_t            rear_cam_x_reg, rear_cam_y_reg, rear_cam_z_reg;
    logic [RAD_W-1:0] cyl_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            front_cam_x_reg <= '0;
            front_cam_y_reg <= '0;
            front_cam_z_reg <= '0;
            rear_cam_x_reg  <= '0;
            rear_cam_y_reg  <= '0;
            rear_cam_z_reg  <= '0;
            cyl_radius_reg  <= RESET_RADIUS;
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_FRONT_CAM_X: front_cam_x_reg <= wr_data;
                REG_FRONT_CAM_Y: front_cam_y_reg <= wr_data;
                REG_FRONT_CAM_Z: front_cam_z_reg <= wr_data;
                REG_REAR_CAM_X:  rear_cam_x_reg  <= wr_data;
                REG_REAR_CAM_Y:  rear_cam_y_reg  <= wr_data;
                REG_REAR_CAM_Z:  rear_cam_z_reg  <= wr_data;
                REG_CYL_RADIUS:  cyl_radius_reg  <= wr_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // pipeline registers
    item_t it0_reg, it1_reg, it2_reg, it3_reg, it4_reg, it5_reg, it6_reg;
    item_t it7_reg, it8_reg, it9_reg;
    item_t d1_reg [DIV_LAT];
    item_t d2_reg [SQRT_LAT];
    item_t d3_reg [DIV_LAT];
    item_t it0_next, it1_next, it2_next, it4_next, it6_next, it7_next;

    logic signed [DIFF_W-1:0] dx0_reg, dy0_reg, dz0_reg;
    logic signed [DIFF_W-1:0] dx0_next, dy0_next, dz0_next;
    logic signed [PROD_W-1:0] mrxcz1_reg, mrxrx1_reg;
    logic signed [PROD_W-1:0] mrxp3_reg, mpp3_reg, mrr3_reg;
    word_t                    c4_reg, c4_next;
    logic signed [PROD_W-1:0] mhh5_reg, mac5_reg;
    logic [PROD_W-1:0]        disc6_reg;
    logic signed [SUM_W-1:0]  disc6_full;
    logic signed [NUM_W-1:0]  n0_7_reg, n1_7_reg;
    logic signed [DEN_W-1:0]  den7_reg;
    logic signed [TERM_W-1:0] t0_7, t1_7, root_t;
    logic signed [PROD_W-1:0] mx0_8_reg, mx1_8_reg, my0_8_reg, my1_8_reg, mycz_8_reg;
    word_t                    z0_8_reg, z1_8_reg, z0_9_reg, z1_9_reg;
    word_t                    x0_9_reg, x1_9_reg, y0_9_reg, y1_9_reg;
    word_t                    x0_9_next, x1_9_next, y0_9_next, y1_9_next;

    logic                     done_reg;
    word_t                    hit_x_reg, hit_y_reg, hit_z_reg;
    logic [ST_W-1:0]          status_reg;
    word_t                    hit_x_next, hit_y_next, hit_z_next;
    logic [ST_W-1:0]          status_next;

    word_t                    rx_q, ry_q, z0_q, z1_q;
    logic [ROOT_W-1:0]        root_q;
    word_t                    cx0, cy0, cz0, cz1, cx2, cz8, cy9;
    logic signed [DIFF_W-1:0] dcy9, dpy9;
    logic                     opp9, same9, pick1;
    word_t                    rad_s;

    // camera picks per stage
    always_comb
    begin
        cx0 = side ? rear_cam_x_reg : front_cam_x_reg;
        cy0 = side ? rear_cam_y_reg : front_cam_y_reg;
        cz0 = side ? rear_cam_z_reg : front_cam_z_reg;
        cz1 = d1_reg[DIV_LAT-1].sel ? rear_cam_z_reg : front_cam_z_reg;
        cx2 = it1_reg.sel ? rear_cam_x_reg : front_cam_x_reg;
        cz8 = d3_reg[DIV_LAT-1].sel ? rear_cam_z_reg : front_cam_z_reg;
        cy9 = it8_reg.sel ? rear_cam_y_reg : front_cam_y_reg;
        rad_s = $signed({1'b0, cyl_radius_reg});
    end

    // stage 0: ray direction differences
    always_comb
    begin
        dx0_next     = DIFF_W'(pt_x) - DIFF_W'(cx0);
        dy0_next     = DIFF_W'(pt_y) - DIFF_W'(cy0);
        dz0_next     = DIFF_W'(pt_z) - DIFF_W'(cz0);
        it0_next     = '0;
        it0_next.v   = start;
        it0_next.sel = side;
        it0_next.zdz = (dz0_next == '0);
        it0_next.py  = pt_y;
    end

    // slopes dx/dz and dy/dz
    rpj_div u_div_rx
    (
        .clk (clk),
        .num (NUM_W'($signed({dx0_reg, {FRAC_BITS{1'b0}}}))),
        .den (DEN_W'(dz0_reg)),
        .quo (rx_q)
    );

    rpj_div u_div_ry
    (
        .clk (clk),
        .num (NUM_W'($signed({dy0_reg, {FRAC_BITS{1'b0}}}))),
        .den (DEN_W'(dz0_reg)),
        .quo (ry_q)
    );

    // stages 1 to 6: quadratic coefficients and discriminant
    always_comb
    begin
        it1_next    = d1_reg[DIV_LAT-1];
        it1_next.rx = rx_q;
        it1_next.ry = ry_q;

        it2_next      = it1_reg;
        it2_next.part = sat32(SUM_W'(cx2) - rs_rnd(mrxcz1_reg));
        it2_next.a    = sat32(rs_rnd(mrxrx1_reg) + FOUR_ONE);

        it4_next   = it3_reg;
        it4_next.h = sat32(rs_rnd(mrxp3_reg));
        c4_next    = sat32(rs_rnd(mpp3_reg) - rs_rnd(mrr3_reg));

        disc6_full   = SUM_W'(mhh5_reg) - SUM_W'(mac5_reg);
        it6_next     = it5_reg;
        it6_next.neg = disc6_full[SUM_W-1];
    end

    rpj_sqrt u_sqrt
    (
        .clk  (clk),
        .rad  (disc6_reg),
        .root (root_q)
    );

    // stage 7: root numerators
    always_comb
    begin
        it7_next = d2_reg[SQRT_LAT-1];
        root_t   = $signed({2'b00, root_q});
        t0_7     = root_t - TERM_W'(it7_next.h);
        t1_7     = -TERM_W'(it7_next.h) - root_t;
    end

    rpj_div u_div_z0
    (
        .clk (clk),
        .num (n0_7_reg),
        .den (den7_reg),
        .quo (z0_q)
    );

    rpj_div u_div_z1
    (
        .clk (clk),
        .num (n1_7_reg),
        .den (den7_reg),
        .quo (z1_q)
    );

    // stage 9: both candidate hit points
    always_comb
    begin
        x0_9_next = sat32(rs_rnd(mx0_8_reg) + SUM_W'(it8_reg.part));
        x1_9_next = sat32(rs_rnd(mx1_8_reg) + SUM_W'(it8_reg.part));
        y0_9_next = sat32(rs_rnd(my0_8_reg) - rs_rnd(mycz_8_reg) + SUM_W'(cy9));
        y1_9_next = sat32(rs_rnd(my1_8_reg) - rs_rnd(mycz_8_reg) + SUM_W'(cy9));
    end

    // stage 10: root choice and status
    always_comb
    begin
        opp9  = (z0_9_reg != '0) && (z1_9_reg != '0) &&
                (z0_9_reg[DATA_W-1] != z1_9_reg[DATA_W-1]);
        dcy9  = DIFF_W'(it9_reg.sel ? rear_cam_y_reg : front_cam_y_reg) - DIFF_W'(it9_reg.py);
        dpy9  = DIFF_W'(it9_reg.py) - DIFF_W'(y0_9_reg);
        same9 = (dcy9 != '0) && (dpy9 != '0) && (dcy9[DIFF_W-1] == dpy9[DIFF_W-1]);
        pick1 = opp9 ? !it9_reg.sel : !same9;
        priority if (it9_reg.zdz) begin
            status_next = ST_PARALLEL;
            hit_x_next  = '0;
            hit_y_next  = '0;
            hit_z_next  = '0;
        end else if (it9_reg.neg) begin
            status_next = ST_NO_ROOT;
            hit_x_next  = '0;
            hit_y_next  = '0;
            hit_z_next  = '0;
        end else begin
            status_next = ST_OK;
            hit_x_next  = pick1 ? x1_9_reg : x0_9_reg;
            hit_y_next  = pick1 ? y1_9_reg : y0_9_reg;
            hit_z_next  = pick1 ? z1_9_reg : z0_9_reg;
        end
    end

    // valid and item pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            it0_reg  <= '0;
            it1_reg  <= '0;
            it2_reg  <= '0;
            it3_reg  <= '0;
            it4_reg  <= '0;
            it5_reg  <= '0;
            it6_reg  <= '0;
            it7_reg  <= '0;
            it8_reg  <= '0;
            it9_reg  <= '0;
            done_reg <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                d1_reg[k] <= '0;
                d3_reg[k] <= '0;
            end
            for (int k = 0; k < SQRT_LAT; k++) begin
                d2_reg[k] <= '0;
            end
        end else begin
            it0_reg   <= it0_next;
            d1_reg[0] <= it0_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                d1_reg[k] <= d1_reg[k-1];
            end
            it1_reg   <= it1_next;
            it2_reg   <= it2_next;
            it3_reg   <= it2_reg;
            it4_reg   <= it4_next;
            it5_reg   <= it4_reg;
            it6_reg   <= it6_next;
            d2_reg[0] <= it6_reg;
            for (int k = 1; k < SQRT_LAT; k++) begin
                d2_reg[k] <= d2_reg[k-1];
            end
            it7_reg   <= it7_next;
            d3_reg[0] <= it7_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                d3_reg[k] <= d3_reg[k-1];
            end
            it8_reg   <= d3_reg[DIV_LAT-1];
            it9_reg   <= it8_reg;
            done_reg  <= it9_reg.v;
        end
    end

    // arithmetic payload, one multiplier level per stage
    always_ff @(posedge clk)
    begin
        dx0_reg    <= dx0_next;
        dy0_reg    <= dy0_next;
        dz0_reg    <= dz0_next;
        mrxcz1_reg <= rx_q * cz1;
        mrxrx1_reg <= rx_q * rx_q;
        mrxp3_reg  <= it2_reg.rx * it2_reg.part;
        mpp3_reg   <= it2_reg.part * it2_reg.part;
        mrr3_reg   <= rad_s * rad_s;
        c4_reg     <= c4_next;
        mhh5_reg   <= it4_reg.h * it4_reg.h;
        mac5_reg   <= it4_reg.a * c4_reg;
        disc6_reg  <= disc6_full[PROD_W-1:0];
        n0_7_reg   <= $signed({t0_7, {FRAC_BITS{1'b0}}});
        n1_7_reg   <= $signed({t1_7, {FRAC_BITS{1'b0}}});
        den7_reg   <= DEN_W'(it7_next.a);
        mx0_8_reg  <= d3_reg[DIV_LAT-1].rx * z0_q;
        mx1_8_reg  <= d3_reg[DIV_LAT-1].rx * z1_q;
        my0_8_reg  <= d3_reg[DIV_LAT-1].ry * z0_q;
        my1_8_reg  <= d3_reg[DIV_LAT-1].ry * z1_q;
        mycz_8_reg <= d3_reg[DIV_LAT-1].ry * cz8;
        z0_8_reg   <= z0_q;
        z1_8_reg   <= z1_q;
        x0_9_reg   <= x0_9_next;
        x1_9_reg   <= x1_9_next;
        y0_9_reg   <= y0_9_next;
        y1_9_reg   <= y1_9_next;
        z0_9_reg   <= z0_8_reg;
        z1_9_reg   <= z1_8_reg;
        hit_x_reg  <= hit_x_next;
        hit_y_reg  <= hit_y_next;
        hit_z_reg  <= hit_z_next;
        status_reg <= status_next;
    end

    assign done   = done_reg;
    assign hit_x  = hit_x_reg;
    assign hit_y  = hit_y_reg;
    assign hit_z  = hit_z_reg;
    assign status = status_reg;

endmodule

`default_nettype wire

// File: src/rpj_checker.sv
// rpj_checker: port-level assertions for the ray projection block, bound to the top
// depends on rpj_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rpj_checker import rpj_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire word_t            hit_x,
    input wire word_t            hit_y,
    input wire word_t            hit_z,
    input wire logic [ST_W-1:0]  status
);

    // status only carries defined codes
    `CHK_IMPLY(a_status_code, clk, rst_n, done, (status == ST_OK || status == ST_NO_ROOT || status == ST_PARALLEL), "undefined status code")

    // a fault result carries a zero point
    `CHK_IMPLY(a_fault_zero, clk, rst_n, done && (status != ST_OK), (hit_x == '0 && hit_y == '0 && hit_z == '0), "fault result with nonzero point")

    // the pipeline never pushes back
    `CHK_ALWAYS(a_never_busy, clk, rst_n, !busy, "busy raised")

    // every result traces back to a transfer a fixed latency earlier
    `CHK_IMPLY(a_latency, clk, rst_n, done, $past(start, PIPE_LAT + 1), "result without matching input transfer")

endmodule

bind ray_elliptic_cylinder_projection rpj_checker u_rpj_checker (.*);

`default_nettype wire
